FILE: hdl/urhb_pkg.sv
`default_nettype none

package urhb_pkg;

  // Request codes on the input channel; code 3 is unused and refused
  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_UNDO = 2'd1,
    REQ_REDO = 2'd2
  } req_t;

  // Result status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Outcome of one request, handed from the controller to the result stage
  typedef struct packed {
    logic ok;    // request done
    logic move;  // undo or redo done, read data carries the value
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/urhb_ram.sv
`default_nettype none

// History storage: one write port, one read port with registered data
module urhb_ram #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [DATA_WIDTH-1:0] wr_data,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/urhb_ctrl.sv
`default_nettype none

// Cursor and fill tracking over a circular slot array.
// cur_ptr_r is the slot of the cursor entry, cur_idx_r its position counted
// from the oldest entry, count_r the number of entries held.
module urhb_ctrl #(
  parameter int DEPTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [1:0]    req,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  output urhb_pkg::res_t     res
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [AW-1:0] KEEP_MAX  = AW'(DEPTH - 2);

  logic [AW-1:0] cur_ptr_r, cur_ptr_nxt;
  logic [AW-1:0] cur_idx_r, cur_idx_nxt;
  logic [AW-1:0] count_r,   count_nxt;

  logic [AW-1:0] ptr_inc, ptr_dec, keep;
  logic          empty, undo_ok, redo_ok;

  // Neighbor slots with wrap
  assign ptr_inc = (cur_ptr_r == LAST_SLOT) ? '0 : cur_ptr_r + AW'(1);
  assign ptr_dec = (cur_ptr_r == '0) ? LAST_SLOT : cur_ptr_r - AW'(1);

  assign empty   = (count_r == '0);
  assign undo_ok = !empty && (cur_idx_r != '0);
  assign redo_ok = !empty && ((cur_idx_r + AW'(1)) != count_r);

  // Entries up to the cursor survive a push; oldest one dropped when full
  always_comb begin
    if (empty) begin
      keep = '0;
    end else if (cur_idx_r >= KEEP_MAX) begin
      keep = KEEP_MAX;
    end else begin
      keep = cur_idx_r + AW'(1);
    end
  end

  // Next state and memory requests
  always_comb begin
    cur_ptr_nxt = cur_ptr_r;
    cur_idx_nxt = cur_idx_r;
    count_nxt   = count_r;
    wr_en       = 1'b0;
    wr_addr     = ptr_inc;
    rd_en       = 1'b0;
    rd_addr     = ptr_dec;
    res         = '{ok: 1'b0, move: 1'b0};
    unique case (req)
      urhb_pkg::REQ_PUSH: begin
        wr_en       = acc;
        cur_ptr_nxt = ptr_inc;
        cur_idx_nxt = keep;
        count_nxt   = keep + AW'(1);
        res         = '{ok: 1'b1, move: 1'b0};
      end
      urhb_pkg::REQ_UNDO: begin
        rd_addr = ptr_dec;
        if (undo_ok) begin
          rd_en       = acc;
          cur_ptr_nxt = ptr_dec;
          cur_idx_nxt = cur_idx_r - AW'(1);
          res         = '{ok: 1'b1, move: 1'b1};
        end
      end
      urhb_pkg::REQ_REDO: begin
        rd_addr = ptr_inc;
        if (redo_ok) begin
          rd_en       = acc;
          cur_ptr_nxt = ptr_inc;
          cur_idx_nxt = cur_idx_r + AW'(1);
          res         = '{ok: 1'b1, move: 1'b1};
        end
      end
      default: begin
        res = '{ok: 1'b0, move: 1'b0};
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_ptr_r <= '0;
      cur_idx_r <= '0;
      count_r   <= '0;
    end else if (acc) begin
      cur_ptr_r <= cur_ptr_nxt;
      cur_idx_r <= cur_idx_nxt;
      count_r   <= count_nxt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_SLOT)
    else $error("history count above capacity");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (cur_idx_r < count_r))
    else $error("cursor outside the held entries");

  a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (cur_idx_r == '0))
    else $error("cursor moved on an empty history");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && req == urhb_pkg::REQ_PUSH) |=> (count_r != '0) && (cur_idx_r + AW'(1) == count_r))
    else $error("push did not leave cursor at newest entry");

endmodule

`default_nettype wire

FILE: hdl/undo_redo_history_buffer.sv
`default_nettype none

// Bounded undo/redo history. Holds up to DEPTH-1 values with a cursor. Push
// (req_type 0) drops the entries after the cursor, appends push_value and
// drops the oldest entry when full; undo (1) and redo (2) move the cursor one
// entry and return the value there, or answer status 1 with value 0 when no
// entry lies that way. Each request gives exactly one result in the cycle after
// its transfer, and a request can be taken every cycle while the result
// channel keeps up; the input stalls only while a result waits at a stalled
// output. Entries live in a DEPTH-slot circular RAM with registered read, so
// no entries are ever moved and a push costs one RAM write.
module undo_redo_history_buffer #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [DATA_WIDTH-1:0] in_push_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_status,
  output logic      [DATA_WIDTH-1:0] out_value_out
);

  localparam int AW = $clog2(DEPTH);

  logic                  acc;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  urhb_pkg::res_t        res;

  logic out_valid_r;
  logic out_ok_r;
  logic out_move_r;

  // Input transfer; held off only while a result sits at a stalled output
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  urhb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .req     (in_req_type),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .res     (res)
  );

  urhb_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_ok_r   <= res.ok;
      out_move_r <= res.move;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_ok_r ? urhb_pkg::STATUS_DONE : urhb_pkg::STATUS_REFUSED;
  assign out_value_out = out_move_r ? rd_data : '0;

endmodule

`default_nettype wire

FILE: tb/sv/history_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the history buffer, keeps its own copy of the
// history and cursor, and compares every result transfer against the oldest
// predicted result.
module history_checker #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [DATA_WIDTH-1:0] in_push_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_status,
  input  logic [DATA_WIDTH-1:0] out_value_out,
  output int                    errors,
  output int                    outstanding
);

  typedef struct packed {
    logic                  status;
    logic [DATA_WIDTH-1:0] value;
  } result_t;

  // History kept oldest first; cursor indexes the current entry
  logic [DATA_WIDTH-1:0] history [$];
  int                    cursor;
  result_t               expected_results [$];
  result_t               want;

  // Apply one request to the shadow history and return its result
  function automatic result_t apply_request(logic [1:0] req, logic [DATA_WIDTH-1:0] val);
    result_t r;
    r.status = urhb_pkg::STATUS_REFUSED;
    r.value  = '0;
    case (req)
      urhb_pkg::REQ_PUSH: begin
        // drop everything after the cursor, then the oldest entry if full
        if (history.size() != 0)
          while (history.size() > cursor + 1) void'(history.pop_back());
        if (history.size() >= DEPTH - 1) void'(history.pop_front());
        history.push_back(val);
        cursor   = history.size() - 1;
        r.status = urhb_pkg::STATUS_DONE;
      end
      urhb_pkg::REQ_UNDO: begin
        if (history.size() != 0 && cursor > 0) begin
          cursor   = cursor - 1;
          r.status = urhb_pkg::STATUS_DONE;
          r.value  = history[cursor];
        end
      end
      urhb_pkg::REQ_REDO: begin
        if (history.size() != 0 && cursor < int'(history.size()) - 1) begin
          cursor   = cursor + 1;
          r.status = urhb_pkg::STATUS_DONE;
          r.value  = history[cursor];
        end
      end
      default: ;  // unused code: refused, no state change
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      history.delete();
      expected_results.delete();
      cursor = 0;
      errors = 0;
      outstanding <= 0;
    end else begin
      // result side first; a request taken now answers on a later edge
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing pending: status %0d value %h",
                 out_status, out_value_out);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            errors++;
          end
          if (out_value_out !== want.value) begin
            $error("value_out mismatch: expected %h, actual %h", want.value, out_value_out);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(in_req_type, in_push_value));
      outstanding <= expected_results.size();
    end
  end

endmodule

FILE: tb/sv/undo_redo_history_buffer_test.sv
`timescale 1ns / 1ps

module undo_redo_history_buffer_test;

  localparam int         DEPTH        = 8;
  localparam int         DATA_WIDTH   = 32;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 700;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         CYCLE_LIMIT  = 200000;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic [1:0]            in_req_type   = urhb_pkg::REQ_PUSH;
  logic [DATA_WIDTH-1:0] in_push_value = '0;
  logic                  out_stall     = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_status;
  logic [DATA_WIDTH-1:0] out_value_out;

  int errors;
  int outstanding;
  int cycles      = 0;
  int items_sent  = 0;
  bit steady      = 1'b0;  // no idling on either side while set
  bit hold_now    = 1'b0;  // asks the receiver for one long hold-off

  undo_redo_history_buffer #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value_out (out_value_out)
  );

  history_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 7);
      end
    end
  end

  // Offer one request and wait for its transfer; maybe idle afterwards
  task automatic send(input logic [1:0] req, input logic [DATA_WIDTH-1:0] val);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_push_value <= val;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return DATA_WIDTH'($urandom);
  endfunction

  function automatic logic [1:0] rand_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return urhb_pkg::REQ_PUSH;
    if (pick < 70) return urhb_pkg::REQ_UNDO;
    if (pick < 95) return urhb_pkg::REQ_REDO;
    return REQ_UNUSED;
  endfunction

  initial begin
    int base;
    bit held;
    bit paused;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty history refusals
    send(urhb_pkg::REQ_UNDO, '1);
    send(urhb_pkg::REQ_REDO, '1);
    send(REQ_UNUSED, '0);
    // single entry, both directions refused
    send(urhb_pkg::REQ_PUSH, '0);
    send(urhb_pkg::REQ_UNDO, '0);
    send(urhb_pkg::REQ_REDO, '0);
    // two entries, walk both ways
    send(urhb_pkg::REQ_PUSH, '1);
    send(urhb_pkg::REQ_UNDO, '0);
    send(urhb_pkg::REQ_UNDO, '0);
    send(urhb_pkg::REQ_REDO, '0);
    // overfill so the oldest entries drop
    for (int i = 0; i < 7; i++)
      send(urhb_pkg::REQ_PUSH, 32'hA5A5_0000 | (32'h1 << (i * 4)));
    send(urhb_pkg::REQ_REDO, '0);
    // push from mid-history discards the entries after the cursor
    repeat (3) send(urhb_pkg::REQ_UNDO, '0);
    send(urhb_pkg::REQ_PUSH, 32'h5A5A_5A5A);
    send(urhb_pkg::REQ_REDO, '0);
    send(REQ_UNUSED, '1);
    repeat (5) send(urhb_pkg::REQ_UNDO, '0);

    // Random part: mixed requests with occasional undo runs
    base   = items_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (items_sent - base < RANDOM_ITEMS) begin
      steady = (items_sent - base >= 250) && (items_sent - base < 370);
      if (!held && items_sent - base >= 150) begin
        held     = 1'b1;
        hold_now = 1'b1;
      end
      if (!paused && items_sent - base >= 450) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(2, 8)) send(urhb_pkg::REQ_UNDO, rand_value());
      else
        send(rand_req(), rand_value());
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
